FILE: sv/orientation_index_table_defines.svh
// ----------------------------------------------------------------------------
// orientation_index_table_defines
// Assertion macros shared by the heading index table.
// ----------------------------------------------------------------------------
`ifndef ORIENTATION_INDEX_TABLE_DEFINES_SVH
`define ORIENTATION_INDEX_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OIT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define OIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/oit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oit_pkg
// Shared types, angle constants and the atan2 angle ROM (signed Q3.13).
// ----------------------------------------------------------------------------
package oit_pkg;

    localparam int TWO_PI_Q13     = 51472;
    localparam int PI_Q13         = 25736;
    localparam int HALF_PI_Q13    = 12868;
    localparam int QUARTER_PI_Q13 = 6434;
    localparam int TQ_PI_Q13      = 19302;
    localparam int LIST_LIMIT     = 32;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_scan_ctl;

    typedef struct packed {
        logic              have;
        logic signed [3:0] x;
        logic signed [3:0] y;
    } t_best;

    // rounded angles for one octant ratio lo/hi:
    // atan, pi - atan, pi/2 - atan, pi/2 + atan
    typedef struct packed {
        logic [14:0] low;
        logic [14:0] pi_m;
        logic [14:0] half_m;
        logic [14:0] half_p;
    } t_oct;

    function automatic t_oct oct_rom(logic [3:0] hi, logic [3:0] lo);
        t_oct v;
        case ({hi, lo}) inside
            8'h21, 8'h42, 8'h63, 8'h84: v = '{15'd3798, 15'd21938, 15'd9070, 15'd16666};
            8'h31, 8'h62:               v = '{15'd2636, 15'd23100, 15'd10232, 15'd15504};
            8'h32, 8'h64:               v = '{15'd4817, 15'd20919, 15'd8051, 15'd17685};
            8'h41, 8'h82:               v = '{15'd2007, 15'd23729, 15'd10861, 15'd14875};
            8'h43, 8'h86:               v = '{15'd5272, 15'd20464, 15'd7596, 15'd18140};
            8'h51:                      v = '{15'd1617, 15'd24119, 15'd11251, 15'd14485};
            8'h52:                      v = '{15'd3117, 15'd22619, 15'd9751, 15'd15985};
            8'h53:                      v = '{15'd4427, 15'd21309, 15'd8441, 15'd17295};
            8'h54:                      v = '{15'd5527, 15'd20208, 15'd7340, 15'd18395};
            8'h61:                      v = '{15'd1353, 15'd24383, 15'd11515, 15'd14221};
            8'h65:                      v = '{15'd5691, 15'd20045, 15'd7177, 15'd18559};
            8'h71:                      v = '{15'd1162, 15'd24574, 15'd11706, 15'd14030};
            8'h72:                      v = '{15'd2280, 15'd23456, 15'd10588, 15'd15148};
            8'h73:                      v = '{15'd3317, 15'd22419, 15'd9551, 15'd16185};
            8'h74:                      v = '{15'd4253, 15'd21483, 15'd8615, 15'd17121};
            8'h75:                      v = '{15'd5081, 15'd20655, 15'd7787, 15'd17949};
            8'h76:                      v = '{15'd5805, 15'd19931, 15'd7063, 15'd18673};
            8'h81:                      v = '{15'd1019, 15'd24717, 15'd11849, 15'd13887};
            8'h83:                      v = '{15'd2939, 15'd22797, 15'd9929, 15'd15807};
            8'h85:                      v = '{15'd4576, 15'd21160, 15'd8292, 15'd17444};
            8'h87:                      v = '{15'd5889, 15'd19847, 15'd6979, 15'd18757};
            default:                    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] angle_q13(logic signed [3:0] x,
                                                     logic signed [3:0] y);
        logic [3:0]  ax;
        logic [3:0]  ay;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic [14:0] mag;
        t_oct        v;
        ax  = x[3] ? 4'(~x + 4'sd1) : 4'(x);
        ay  = y[3] ? 4'(~y + 4'sd1) : 4'(y);
        hi  = (ay < ax) ? ax : ay;
        lo  = (ay < ax) ? ay : ax;
        v   = oct_rom(hi, lo);
        if (ax == 4'd0 && ay == 4'd0) begin
            mag = '0;
        end else if (ay == 4'd0) begin
            mag = x[3] ? 15'(PI_Q13) : 15'd0;
        end else if (ax == 4'd0) begin
            mag = 15'(HALF_PI_Q13);
        end else if (ax == ay) begin
            mag = x[3] ? 15'(TQ_PI_Q13) : 15'(QUARTER_PI_Q13);
        end else if (ay < ax) begin
            mag = x[3] ? v.pi_m : v.low;
        end else begin
            mag = x[3] ? v.half_p : v.half_m;
        end
        return y[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

FILE: sv/oit_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oit_store
// Grid cell memory (entry number per cell) and entry vector memory,
// each with one write port and one registered read port.
// ----------------------------------------------------------------------------
module oit_store #(
    parameter int GRID_CELLS  = 225,
    parameter int GW          = 8,
    parameter int MAX_ENTRIES = 32,
    parameter int EW          = 5
) (
    input  logic          i_clk,
    input  logic          i_grid_we,
    input  logic [GW-1:0] i_grid_waddr,
    input  logic [EW-1:0] i_grid_wdata,
    input  logic          i_grid_re,
    input  logic [GW-1:0] i_grid_raddr,
    output logic [EW-1:0] o_grid_q,
    input  logic          i_ent_we,
    input  logic [EW-1:0] i_ent_waddr,
    input  logic [7:0]    i_ent_wdata,
    input  logic          i_ent_re,
    input  logic [EW-1:0] i_ent_raddr,
    output logic [7:0]    o_ent_q
);

    logic [EW-1:0] r_grid [GRID_CELLS];
    logic [7:0]    r_vec  [MAX_ENTRIES];
    logic [EW-1:0] r_grid_q;
    logic [7:0]    r_ent_q;

    always_ff @(posedge i_clk) begin
        if (i_grid_we) begin
            r_grid[i_grid_waddr] <= i_grid_wdata;
        end
        if (i_grid_re) begin
            r_grid_q <= r_grid[i_grid_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_vec[i_ent_waddr] <= i_ent_wdata;
        end
        if (i_ent_re) begin
            r_ent_q <= r_vec[i_ent_raddr];
        end
    end

    assign o_grid_q = r_grid_q;
    assign o_ent_q  = r_ent_q;

endmodule

FILE: sv/oit_best.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oit_best
// Shared yaw error unit: angle lookup and |angle - yaw| in one stage,
// compare against the running best in the next. Ties go to the cell
// first in row-major order.
// ----------------------------------------------------------------------------
module oit_best #(
    parameter int EW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oit_pkg::t_scan_ctl  i_ctl,
    input  logic signed [3:0]   i_x,
    input  logic signed [3:0]   i_y,
    input  logic [EW-1:0]       i_num,
    input  logic signed [15:0]  i_yaw,
    output oit_pkg::t_best      o_best,
    output logic [EW-1:0]       o_num
);

    logic signed [15:0] ang;
    logic signed [17:0] diff;
    logic [16:0]        err;
    logic               take;

    logic               r_vld;
    logic [16:0]        r_err;
    logic [7:0]         r_key;
    logic signed [3:0]  r_x;
    logic signed [3:0]  r_y;
    logic [EW-1:0]      r_num;

    logic               r_have;
    logic [16:0]        r_berr;
    logic [7:0]         r_bkey;
    logic signed [3:0]  r_bx;
    logic signed [3:0]  r_by;
    logic [EW-1:0]      r_bnum;

    always_comb begin
        ang  = oit_pkg::angle_q13(i_x, i_y);
        diff = 18'(ang) - 18'(i_yaw);
        err  = diff[17] ? 17'(-diff) : 17'(diff);
    end

    always_comb begin
        if (r_have) begin
            take = r_vld && ((r_err < r_berr) || (r_err == r_berr && r_key < r_bkey));
        end else begin
            take = r_vld && (r_err < 17'(oit_pkg::TWO_PI_Q13));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_have <= 1'b0;
        end else if (i_ctl.clr) begin
            r_vld  <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_vld <= i_ctl.vld;
            if (take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= err;
        r_key <= {~i_y[3], i_y[2:0], ~i_x[3], i_x[2:0]};
        r_x   <= i_x;
        r_y   <= i_y;
        r_num <= i_num;
        if (take) begin
            r_berr <= r_err;
            r_bkey <= r_key;
            r_bx   <= r_x;
            r_by   <= r_y;
            r_bnum <= r_num;
        end
    end

    assign o_best = '{have: r_have, x: r_bx, y: r_by};
    assign o_num  = r_bnum;

endmodule

FILE: sv/orientation_index_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orientation_index_table
// Square grid of lattice heading vectors with dense indices in insertion
// order: clear, insert, index lookup, nearest-yaw search and listing.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  request   | start / busy       | i_req_type, i_x_comp, i_y_comp, i_yaw
//  result    | o_valid (strobe)   | o_index, o_x_out, o_y_out, o_found,
//            |                    | o_error_flag, o_entry_count, o_last
//
//  Clear and rejected requests need no memory read; insert and lookup read
//  the grid memory, then the entry memory.
//  Nearest yaw: one stored entry per cycle through the
//  shared angle error unit. List: one result per cycle, one per stored entry, at most LIST_LIMIT.
//  After reset a clearing pass over all GRID_CELLS cells (225 by default) zeroes
//  the grid memory; busy stays high meanwhile.
//  Results are strobed for one cycle and are never held off.
// ----------------------------------------------------------------------------
`include "orientation_index_table_defines.svh"

module orientation_index_table #(
    parameter int MAX_COMPONENT = 7,
    parameter int MAX_ENTRIES   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic signed [3:0]  i_x_comp,
    input  logic signed [3:0]  i_y_comp,
    input  logic signed [15:0] i_yaw,
    output logic               o_valid,
    output logic [5:0]         o_index,
    output logic signed [3:0]  o_x_out,
    output logic signed [3:0]  o_y_out,
    output logic               o_found,
    output logic               o_error_flag,
    output logic [5:0]         o_entry_count,
    output logic               o_last
);

    localparam int SIDE       = 2 * MAX_COMPONENT + 1;
    localparam int GRID_CELLS = SIDE * SIDE;
    localparam int GW         = $clog2(GRID_CELLS);
    localparam int EW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW         = $clog2(MAX_ENTRIES + 1);
    localparam int LIST_MAX   = (MAX_ENTRIES < oit_pkg::LIST_LIMIT) ?
                                MAX_ENTRIES : oit_pkg::LIST_LIMIT;

    typedef enum logic [2:0] {
        REQ_CLEAR   = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_LOOKUP  = 3'd2,
        REQ_NEAREST = 3'd3,
        REQ_LIST    = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_GRID,
        S_VEC,
        S_SCAN,
        S_WAIT,
        S_FIN,
        S_LIST
    } t_state;

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic signed [3:0]  r_x, n_x;
    logic signed [3:0]  r_y, n_y;
    logic signed [15:0] r_yaw, n_yaw;
    logic [GW-1:0]      r_cell, n_cell;
    logic [EW-1:0]      r_num, n_num;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;

    logic               r_ovld, n_ovld;
    logic [5:0]         r_index, n_index;
    logic signed [3:0]  r_xo, n_xo;
    logic signed [3:0]  r_yo, n_yo;
    logic               r_found, n_found;
    logic               r_err, n_err;
    logic [5:0]         r_cnt_o, n_cnt_o;
    logic               r_last, n_last;

    logic               grid_we;
    logic [GW-1:0]      grid_waddr;
    logic [EW-1:0]      grid_wdata;
    logic               grid_re;
    logic [GW-1:0]      grid_raddr;
    logic [EW-1:0]      grid_q;
    logic               ent_we;
    logic [EW-1:0]      ent_waddr;
    logic               ent_re;
    logic [EW-1:0]      ent_raddr;
    logic [7:0]         ent_q;

    oit_pkg::t_scan_ctl scan_ctl;
    oit_pkg::t_best     best;
    logic [EW-1:0]      best_num;

    logic               in_grid;
    logic [GW-1:0]      cell_in;
    logic               hit;
    logic [CW-1:0]      list_n;

    oit_store #(
        .GRID_CELLS  (GRID_CELLS),
        .GW          (GW),
        .MAX_ENTRIES (MAX_ENTRIES),
        .EW          (EW)
    ) u_store (
        .i_clk        (i_clk),
        .i_grid_we    (grid_we),
        .i_grid_waddr (grid_waddr),
        .i_grid_wdata (grid_wdata),
        .i_grid_re    (grid_re),
        .i_grid_raddr (grid_raddr),
        .o_grid_q     (grid_q),
        .i_ent_we     (ent_we),
        .i_ent_waddr  (ent_waddr),
        .i_ent_wdata  ({r_x, r_y}),
        .i_ent_re     (ent_re),
        .i_ent_raddr  (ent_raddr),
        .o_ent_q      (ent_q)
    );

    oit_best #(
        .EW (EW)
    ) u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_x     (ent_q[7:4]),
        .i_y     (ent_q[3:0]),
        .i_num   (EW'(r_k - CW'(1))),
        .i_yaw   (r_yaw),
        .o_best  (best),
        .o_num   (best_num)
    );

    always_comb begin
        in_grid = (int'(i_x_comp) >= -MAX_COMPONENT) && (int'(i_x_comp) <= MAX_COMPONENT) &&
                  (int'(i_y_comp) >= -MAX_COMPONENT) && (int'(i_y_comp) <= MAX_COMPONENT);
        cell_in = GW'((int'(i_y_comp) + MAX_COMPONENT) * SIDE +
                      int'(i_x_comp) + MAX_COMPONENT);
        hit     = (CW'(r_num) < r_count) && (ent_q == {r_x, r_y});
        list_n  = (r_count > CW'(LIST_MAX)) ? CW'(LIST_MAX) : r_count;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_x        = r_x;
        n_y        = r_y;
        n_yaw      = r_yaw;
        n_cell     = r_cell;
        n_num      = r_num;
        n_count    = r_count;
        n_k        = r_k;
        n_ovld     = 1'b0;
        n_index    = '0;
        n_xo       = '0;
        n_yo       = '0;
        n_found    = 1'b0;
        n_err      = 1'b0;
        n_last     = 1'b1;
        grid_we    = 1'b0;
        grid_waddr = r_cell;
        grid_wdata = '0;
        grid_re    = 1'b0;
        grid_raddr = cell_in;
        ent_we     = 1'b0;
        ent_waddr  = r_count[EW-1:0];
        ent_re     = 1'b0;
        ent_raddr  = '0;
        scan_ctl   = '{clr: 1'b0, vld: 1'b0};

        unique case (r_state)
            S_INIT: begin
                grid_we = 1'b1;
                if (r_cell == GW'(GRID_CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cell = r_cell + GW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req = t_req'(i_req_type);
                    n_x   = i_x_comp;
                    n_y   = i_y_comp;
                    n_yaw = i_yaw;
                    n_cell = cell_in;
                    unique case (t_req'(i_req_type))
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_ovld  = 1'b1;
                        end
                        REQ_INSERT, REQ_LOOKUP: begin
                            if (in_grid) begin
                                grid_re = 1'b1;
                                n_state = S_GRID;
                            end else begin
                                n_ovld = 1'b1;
                                n_err  = 1'b1;
                            end
                        end
                        REQ_NEAREST: begin
                            scan_ctl.clr = 1'b1;
                            if (r_count == '0) begin
                                n_ovld = 1'b1;
                            end else begin
                                ent_re  = 1'b1;
                                n_k     = CW'(1);
                                n_state = S_SCAN;
                            end
                        end
                        REQ_LIST: begin
                            if (r_count == '0) begin
                                n_ovld = 1'b1;
                            end else begin
                                ent_re  = 1'b1;
                                n_k     = CW'(1);
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_ovld = 1'b1;
                        end
                    endcase
                end
            end
            S_GRID: begin
                ent_re    = 1'b1;
                ent_raddr = grid_q;
                n_num     = grid_q;
                n_state   = S_VEC;
            end
            S_VEC: begin
                n_ovld  = 1'b1;
                n_state = S_IDLE;
                if (hit) begin
                    n_index = 6'(CW'(r_num) + CW'(1));
                    n_xo    = r_x;
                    n_yo    = r_y;
                    n_found = 1'b1;
                end else if (r_req == REQ_INSERT) begin
                    if (r_count >= CW'(MAX_ENTRIES)) begin
                        n_err = 1'b1;
                    end else begin
                        grid_we    = 1'b1;
                        grid_wdata = r_count[EW-1:0];
                        ent_we     = 1'b1;
                        n_count    = r_count + CW'(1);
                        n_index    = 6'(r_count + CW'(1));
                        n_xo       = r_x;
                        n_yo       = r_y;
                        n_found    = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                scan_ctl.vld = 1'b1;
                if (r_k == r_count) begin
                    n_state = S_WAIT;
                end else begin
                    ent_re    = 1'b1;
                    ent_raddr = r_k[EW-1:0];
                    n_k       = r_k + CW'(1);
                end
            end
            S_WAIT: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_ovld  = 1'b1;
                n_state = S_IDLE;
                if (best.have) begin
                    n_index = 6'(CW'(best_num) + CW'(1));
                    n_xo    = best.x;
                    n_yo    = best.y;
                    n_found = 1'b1;
                end
            end
            S_LIST: begin
                n_ovld  = 1'b1;
                n_index = 6'(r_k);
                n_xo    = ent_q[7:4];
                n_yo    = ent_q[3:0];
                n_found = 1'b1;
                n_last  = (r_k == list_n);
                if (r_k == list_n) begin
                    n_state = S_IDLE;
                end else begin
                    ent_re    = 1'b1;
                    ent_raddr = r_k[EW-1:0];
                    n_k       = r_k + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_cnt_o = 6'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cell  <= '0;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cell  <= n_cell;
            r_count <= n_count;
            r_ovld  <= n_ovld;
        end
        r_req   <= n_req;
        r_x     <= n_x;
        r_y     <= n_y;
        r_yaw   <= n_yaw;
        r_num   <= n_num;
        r_k     <= n_k;
        r_index <= n_index;
        r_xo    <= n_xo;
        r_yo    <= n_yo;
        r_found <= n_found;
        r_err   <= n_err;
        r_cnt_o <= n_cnt_o;
        r_last  <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_ovld;
    assign o_index       = r_index;
    assign o_x_out       = r_xo;
    assign o_y_out       = r_yo;
    assign o_found       = r_found;
    assign o_error_flag  = r_err;
    assign o_entry_count = r_cnt_o;
    assign o_last        = r_last;

    `OIT_ASSERT_NOW(a_count_bound, r_state != S_INIT, r_count <= CW'(MAX_ENTRIES), "entry count above table size")
    `OIT_ASSERT_NOW(a_err_not_found, o_valid && o_error_flag, !o_found && o_index == '0, "error result names a vector")
    `OIT_ASSERT_NEXT(a_list_runs, o_valid && o_found && !o_last, o_valid && o_found, "list items not back to back")
    `OIT_ASSERT_NOW(a_walk_range, r_state == S_LIST || r_state == S_SCAN, r_k != '0 && r_k <= r_count, "entry walk out of range")

endmodule
